FILE: hdl/lrca_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrca_pkg
// Shared widths, register indexes and controller/datapath interface types for
// the lattice radius class assigner.
// ----------------------------------------------------------------------------
package lrca_pkg;

  localparam int unsigned MAX_CLASSES_DEF = 256;

  localparam int unsigned COORD_W  = 8;
  localparam int unsigned EXTENT_W = 9;
  localparam int unsigned INDEX_W  = 16;
  localparam int unsigned ID_W     = 8;
  localparam int unsigned RADIUS_W = 17;
  localparam int unsigned COUNT_W  = 17;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 9;
  localparam int unsigned NUM_DIRS = 4;

  localparam logic [COUNT_W-1:0]  COUNT_MAX  = '1;
  localparam logic [RADIUS_W-1:0] RADIUS_MAX = '1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_EXTENT_T = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_EXTENT_X = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_EXTENT_Y = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_EXTENT_Z = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_T = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_X = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_Y = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_Z = 3'd7;

  localparam logic [EXTENT_W-1:0] EXTENT_RESET = 9'd16;

  typedef struct packed {
    logic load;       // latch a new item, restart the scan
    logic idx_inc;    // advance scan index
    logic emit_hit;   // radius found at scan index
    logic emit_new;   // open the next free class
    logic emit_full;  // no match, no free class
  } lrca_cmd_t;

  typedef struct packed {
    logic match;  // entry at scan index holds the radius
    logic last;   // scan index is the last class in use
    logic empty;  // no class in use
    logic room;   // a free class remains
  } lrca_status_t;

endpackage

FILE: hdl/lattice_radius_class_assigner.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lattice_radius_class_assigner
// Assigns each lattice site to a class of equal squared periodic radius from
// a configured source point and reports the class and its member count.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low. Its result shows on
// the output ports for one cycle with done high and must be captured then;
// there is no way to hold it off. The radius passes the wrap, square and sum
// registers, then the class table, if not empty, is scanned one entry at a time,
// each entry a read through its registered memory port and a compare. Busy drops
// in the result strobe cycle so the next start can be taken there.
// Configuration is written through cfg_we/cfg_index/cfg_data while idle.
// ----------------------------------------------------------------------------
module lattice_radius_class_assigner #(
  parameter int unsigned MAX_CLASSES = lrca_pkg::MAX_CLASSES_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [lrca_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [lrca_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                              start,
  output logic                              busy,
  input  logic [lrca_pkg::COORD_W-1:0]      site_t,
  input  logic [lrca_pkg::COORD_W-1:0]      site_x,
  input  logic [lrca_pkg::COORD_W-1:0]      site_y,
  input  logic [lrca_pkg::COORD_W-1:0]      site_z,
  input  logic [lrca_pkg::INDEX_W-1:0]      site_index,
  output logic                              done,
  output logic [lrca_pkg::INDEX_W-1:0]      out_site_index,
  output logic [lrca_pkg::ID_W-1:0]         class_id,
  output logic [lrca_pkg::RADIUS_W-1:0]     radius_sq,
  output logic                              is_new_class,
  output logic [lrca_pkg::COUNT_W-1:0]      class_count,
  output logic                              table_full
);
  import lrca_pkg::*;

  lrca_cmd_t    cmd;
  lrca_status_t status;

  lrca_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .cmd    (cmd),
    .status (status)
  );

  lrca_datapath #(
    .MAX_CLASSES (MAX_CLASSES)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .site_t         (site_t),
    .site_x         (site_x),
    .site_y         (site_y),
    .site_z         (site_z),
    .site_index     (site_index),
    .cmd            (cmd),
    .status         (status),
    .done           (done),
    .out_site_index (out_site_index),
    .class_id       (class_id),
    .radius_sq      (radius_sq),
    .is_new_class   (is_new_class),
    .class_count    (class_count),
    .table_full     (table_full)
  );

endmodule

FILE: hdl/lrca_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrca_ctrl
// Sequencer: waits out the radius pipeline, then scans the class table one
// entry per read/compare pair and picks hit, new class or table full.
// ----------------------------------------------------------------------------
module lrca_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  output lrca_pkg::lrca_cmd_t   cmd,
  input  lrca_pkg::lrca_status_t status
);
  import lrca_pkg::*;

  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_WRAP    = 3'd1;
  localparam logic [2:0] ST_SQUARE  = 3'd2;
  localparam logic [2:0] ST_SUM     = 3'd3;
  localparam logic [2:0] ST_LOOKUP  = 3'd4;
  localparam logic [2:0] ST_COMPARE = 3'd5;

  logic [2:0] state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          state_next = ST_WRAP;
        end
      end
      ST_WRAP:   state_next = ST_SQUARE;
      ST_SQUARE: state_next = ST_SUM;
      ST_SUM:    state_next = ST_LOOKUP;
      ST_LOOKUP: begin
        if (status.empty) begin
          cmd.emit_new  = status.room;
          cmd.emit_full = !status.room;
          state_next = ST_IDLE;
        end else begin
          state_next = ST_COMPARE;
        end
      end
      ST_COMPARE: begin
        if (status.match) begin
          cmd.emit_hit = 1'b1;
          state_next = ST_IDLE;
        end else if (status.last) begin
          cmd.emit_new  = status.room;
          cmd.emit_full = !status.room;
          state_next = ST_IDLE;
        end else begin
          cmd.idx_inc = 1'b1;
          state_next = ST_LOOKUP;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  assign busy = (state != ST_IDLE);

endmodule

FILE: hdl/lrca_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrca_datapath
// Configuration registers, wrapped-displacement lanes, squared-radius sum,
// class radius and member count memories, and the result register.
// ----------------------------------------------------------------------------
module lrca_datapath #(
  parameter int unsigned MAX_CLASSES = lrca_pkg::MAX_CLASSES_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [lrca_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [lrca_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic [lrca_pkg::COORD_W-1:0]      site_t,
  input  logic [lrca_pkg::COORD_W-1:0]      site_x,
  input  logic [lrca_pkg::COORD_W-1:0]      site_y,
  input  logic [lrca_pkg::COORD_W-1:0]      site_z,
  input  logic [lrca_pkg::INDEX_W-1:0]      site_index,
  input  lrca_pkg::lrca_cmd_t               cmd,
  output lrca_pkg::lrca_status_t            status,
  output logic                              done,
  output logic [lrca_pkg::INDEX_W-1:0]      out_site_index,
  output logic [lrca_pkg::ID_W-1:0]         class_id,
  output logic [lrca_pkg::RADIUS_W-1:0]     radius_sq,
  output logic                              is_new_class,
  output logic [lrca_pkg::COUNT_W-1:0]      class_count,
  output logic                              table_full
);
  import lrca_pkg::*;

  localparam int unsigned IDX_W = (MAX_CLASSES > 1) ? $clog2(MAX_CLASSES) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_CLASSES + 1);
  localparam int unsigned D_W   = 11;  // signed displacement after one wrap
  localparam int unsigned ABS_W = 10;
  localparam int unsigned SQ_W  = 2 * ABS_W;
  localparam int unsigned SUM_W = SQ_W + 2;

  // Configuration
  logic [EXTENT_W-1:0] extent [NUM_DIRS];
  logic [COORD_W-1:0]  source [NUM_DIRS];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_DIRS; i++) begin
        extent[i] <= EXTENT_RESET;
        source[i] <= '0;
      end
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_EXTENT_T: extent[0] <= cfg_data;
        REG_EXTENT_X: extent[1] <= cfg_data;
        REG_EXTENT_Y: extent[2] <= cfg_data;
        REG_EXTENT_Z: extent[3] <= cfg_data;
        REG_SOURCE_T: source[0] <= cfg_data[COORD_W-1:0];
        REG_SOURCE_X: source[1] <= cfg_data[COORD_W-1:0];
        REG_SOURCE_Y: source[2] <= cfg_data[COORD_W-1:0];
        REG_SOURCE_Z: source[3] <= cfg_data[COORD_W-1:0];
        default: ;
      endcase
    end
  end

  // Item capture
  logic [COORD_W-1:0] site_q [NUM_DIRS];
  logic [INDEX_W-1:0] index_q;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      site_q[0] <= site_t;
      site_q[1] <= site_x;
      site_q[2] <= site_y;
      site_q[3] <= site_z;
      index_q   <= site_index;
    end
  end

  // Radius pipeline: wrap, square, sum. Free running on the held item.
  logic signed [D_W-1:0] d_raw [NUM_DIRS];
  logic signed [D_W-1:0] d_wrap [NUM_DIRS];
  logic signed [D_W-1:0] half_s [NUM_DIRS];
  logic signed [D_W-1:0] len_s [NUM_DIRS];
  logic [ABS_W-1:0] d_abs [NUM_DIRS];
  logic [SQ_W-1:0]  d_sq [NUM_DIRS];
  logic [SUM_W-1:0] sum;
  logic [RADIUS_W-1:0] radius;

  always_comb begin
    for (int i = 0; i < NUM_DIRS; i++) begin
      d_raw[i]  = $signed({3'b000, site_q[i]}) - $signed({3'b000, source[i]});
      len_s[i]  = $signed({2'b00, extent[i]});
      half_s[i] = $signed({3'b000, extent[i][EXTENT_W-1:1]});
      if (d_raw[i] > half_s[i]) begin
        d_wrap[i] = d_raw[i] - len_s[i];
      end else if (d_raw[i] <= -half_s[i]) begin
        d_wrap[i] = d_raw[i] + len_s[i];
      end else begin
        d_wrap[i] = d_raw[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < NUM_DIRS; i++) begin
      d_abs[i] <= d_wrap[i][D_W-1] ? ABS_W'(-d_wrap[i]) : ABS_W'(d_wrap[i]);
      d_sq[i]  <= d_abs[i] * d_abs[i];
    end
    radius <= (sum[SUM_W-1:RADIUS_W] != '0) ? RADIUS_MAX : sum[RADIUS_W-1:0];
  end

  assign sum = SUM_W'(d_sq[0]) + SUM_W'(d_sq[1]) + SUM_W'(d_sq[2]) + SUM_W'(d_sq[3]);

  // Class table
  logic [RADIUS_W-1:0] radius_mem  [MAX_CLASSES];
  logic [COUNT_W-1:0]  members_mem [MAX_CLASSES];
  logic [RADIUS_W-1:0] rd_radius;
  logic [COUNT_W-1:0]  rd_members;
  logic [IDX_W-1:0]    idx;
  logic [CNT_W-1:0]    in_use;
  logic [IDX_W-1:0]    new_idx;
  logic [IDX_W-1:0]    wr_addr;
  logic [COUNT_W-1:0]  hit_count;
  logic [COUNT_W-1:0]  wr_count;

  assign new_idx   = in_use[IDX_W-1:0];
  assign hit_count = (rd_members < COUNT_MAX) ? rd_members + COUNT_W'(1) : rd_members;
  assign wr_addr   = cmd.emit_hit ? idx : new_idx;
  assign wr_count  = cmd.emit_hit ? hit_count : COUNT_W'(1);

  always_ff @(posedge clk) begin
    rd_radius  <= radius_mem[idx];
    rd_members <= members_mem[idx];
    if (cmd.emit_new) begin
      radius_mem[new_idx] <= radius;
    end
    if (cmd.emit_hit || cmd.emit_new) begin
      members_mem[wr_addr] <= wr_count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx    <= '0;
      in_use <= '0;
    end else begin
      if (cmd.load) begin
        idx <= '0;
      end else if (cmd.idx_inc) begin
        idx <= idx + IDX_W'(1);
      end
      if (cmd.emit_new) begin
        in_use <= in_use + CNT_W'(1);
      end
    end
  end

  assign status.match = (rd_radius == radius);
  assign status.last  = ((CNT_W'(idx) + CNT_W'(1)) == in_use);
  assign status.empty = (in_use == '0);
  assign status.room  = (in_use < CNT_W'(MAX_CLASSES));

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.emit_hit || cmd.emit_new || cmd.emit_full;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_hit || cmd.emit_new || cmd.emit_full) begin
      out_site_index <= index_q;
      radius_sq      <= radius;
      is_new_class   <= cmd.emit_new;
      table_full     <= cmd.emit_full;
      if (cmd.emit_hit) begin
        class_id    <= ID_W'(idx);
        class_count <= hit_count;
      end else if (cmd.emit_new) begin
        class_id    <= ID_W'(new_idx);
        class_count <= COUNT_W'(1);
      end else begin
        class_id    <= '0;
        class_count <= '0;
      end
    end
  end

endmodule

FILE: hdl/lrca_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrca_checker
// Port-level checks on the lattice radius class assigner, bound to the top.
// ----------------------------------------------------------------------------
module lrca_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              start,
  input logic                              busy,
  input logic                              done,
  input logic [lrca_pkg::ID_W-1:0]         class_id,
  input logic                              is_new_class,
  input logic [lrca_pkg::COUNT_W-1:0]      class_count,
  input logic                              table_full
);

  // An accepted item keeps the block busy through the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("busy not raised after an accepted item");

  // A result only appears once the block has gone idle.
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while busy");

  // A new class starts with exactly one member and is never a full miss.
  a_new_count: assert property (@(posedge clk) disable iff (rst)
    done && is_new_class |-> class_count == 17'd1 && !table_full)
    else $error("new class with bad count or full flag");

  // A full miss reports class zero and no members.
  a_full_zero: assert property (@(posedge clk) disable iff (rst)
    done && table_full |-> class_id == 8'd0 && class_count == 17'd0)
    else $error("table full result not cleared");

  // A found class always has at least two members.
  a_hit_count: assert property (@(posedge clk) disable iff (rst)
    done && !is_new_class && !table_full |-> class_count >= 17'd2)
    else $error("hit with member count below two");

endmodule

bind lattice_radius_class_assigner lrca_checker u_lrca_checker (.*);

FILE: test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the lattice radius class assigner. Sites go in
// through start/busy in bursts with random gaps. Each one is scored against
// a local class list built from the same wrap and radius rules. The run
// sweeps many lattice geometries, fills the class list and then keeps
// sending sites once no class entry is free.
// ----------------------------------------------------------------------------
module testbench;
  import lrca_pkg::*;

  localparam int unsigned CLASS_SLOTS  = MAX_CLASSES_DEF;
  localparam int unsigned BULK_END     = 1750;
  localparam int unsigned IDLE_LIMIT   = 4000;
  localparam int unsigned DRAIN_CYCLES = 600;
  localparam int unsigned REPORT_LIMIT = 10;

  typedef struct packed {
    logic [COORD_W-1:0] t;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] z;
    logic [INDEX_W-1:0] index;
  } site_item_t;

  typedef struct packed {
    logic [INDEX_W-1:0]  site_index;
    logic [ID_W-1:0]     class_id;
    logic [RADIUS_W-1:0] radius_sq;
    logic                fresh;
    logic [COUNT_W-1:0]  count;
    logic                full;
  } class_result_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  start = 1'b0;
  logic                  busy;
  logic [COORD_W-1:0]    site_t = '0;
  logic [COORD_W-1:0]    site_x = '0;
  logic [COORD_W-1:0]    site_y = '0;
  logic [COORD_W-1:0]    site_z = '0;
  logic [INDEX_W-1:0]    site_index = '0;
  logic                  done;
  logic [INDEX_W-1:0]    out_site_index;
  logic [ID_W-1:0]       class_id;
  logic [RADIUS_W-1:0]   radius_sq;
  logic                  is_new_class;
  logic [COUNT_W-1:0]    class_count;
  logic                  table_full;

  lattice_radius_class_assigner u_top (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .start          (start),
    .busy           (busy),
    .site_t         (site_t),
    .site_x         (site_x),
    .site_y         (site_y),
    .site_z         (site_z),
    .site_index     (site_index),
    .done           (done),
    .out_site_index (out_site_index),
    .class_id       (class_id),
    .radius_sq      (radius_sq),
    .is_new_class   (is_new_class),
    .class_count    (class_count),
    .table_full     (table_full)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Shadow of the geometry registers, reset values first
  logic [EXTENT_W-1:0] ext_t = EXTENT_RESET;
  logic [EXTENT_W-1:0] ext_x = EXTENT_RESET;
  logic [EXTENT_W-1:0] ext_y = EXTENT_RESET;
  logic [EXTENT_W-1:0] ext_z = EXTENT_RESET;
  logic [COORD_W-1:0]  src_t = '0;
  logic [COORD_W-1:0]  src_x = '0;
  logic [COORD_W-1:0]  src_y = '0;
  logic [COORD_W-1:0]  src_z = '0;

  // Class list as the block should hold it
  logic [RADIUS_W-1:0] known_radius [CLASS_SLOTS];
  logic [COUNT_W-1:0]  member_total [CLASS_SLOTS];
  int unsigned         classes_open = 0;

  site_item_t    site_queue[$];
  site_item_t    site_on_port;
  class_result_t results_due[$];
  class_result_t seen_result;
  class_result_t due_result;

  int unsigned sites_pushed = 0;
  int unsigned sites_accepted = 0;
  int unsigned sites_refused = 0;
  int unsigned results_checked = 0;
  int unsigned settings_applied = 0;
  int unsigned faults = 0;
  int unsigned quiet_cycles = 0;
  int unsigned gap_left = 0;
  int unsigned burst_left = 0;

  function automatic int unsigned wrap_square(input logic [COORD_W-1:0] pos,
                                              input logic [COORD_W-1:0] src,
                                              input logic [EXTENT_W-1:0] ext);
    int d;
    int span;
    d = int'(pos) - int'(src);
    span = int'(ext);
    // wrap once only, even for coordinates beyond the extent
    if (d > span / 2) d -= span;
    else if (d <= -(span / 2)) d += span;
    if (d < 0) d = -d;
    return unsigned'(d * d);
  endfunction

  function automatic class_result_t classify_site(input site_item_t s);
    int unsigned   r;
    int            hit;
    class_result_t res;
    r = wrap_square(s.t, src_t, ext_t) + wrap_square(s.x, src_x, ext_x) +
        wrap_square(s.y, src_y, ext_y) + wrap_square(s.z, src_z, ext_z);
    if (r > 32'(RADIUS_MAX)) r = 32'(RADIUS_MAX);
    hit = -1;
    for (int i = 0; i < int'(classes_open); i++) begin
      if (known_radius[i] == r[RADIUS_W-1:0]) begin
        hit = i;
        break;
      end
    end
    res.site_index = s.index;
    res.radius_sq  = r[RADIUS_W-1:0];
    res.fresh      = 1'b0;
    res.full       = 1'b0;
    if (hit >= 0) begin
      if (member_total[hit] != COUNT_MAX) member_total[hit] = member_total[hit] + 1'b1;
      res.class_id = hit[ID_W-1:0];
      res.count    = member_total[hit];
    end else if (classes_open < CLASS_SLOTS) begin
      known_radius[classes_open] = r[RADIUS_W-1:0];
      member_total[classes_open] = COUNT_W'(1);
      res.class_id = classes_open[ID_W-1:0];
      res.count    = COUNT_W'(1);
      res.fresh    = 1'b1;
      classes_open++;
    end else begin
      res.class_id = '0;
      res.count    = '0;
      res.full     = 1'b1;
      sites_refused++;
    end
    return res;
  endfunction

  // Driver: hold each item until busy is low, then run bursts and gaps
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
      gap_left = 0;
      burst_left = 0;
    end else begin
      if (start && !busy) begin
        results_due.push_back(classify_site(site_on_port));
        sites_accepted++;
      end
      if (!start || !busy) begin
        if (gap_left > 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (site_queue.size() > 0) begin
          site_on_port = site_queue.pop_front();
          site_t     <= site_on_port.t;
          site_x     <= site_on_port.x;
          site_y     <= site_on_port.y;
          site_z     <= site_on_port.z;
          site_index <= site_on_port.index;
          start      <= 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 40);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 24);
          end
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: an unknown strobe counts as a result so it cannot slip by
  always @(posedge clk) begin
    if (!rst && done !== 1'b0) begin
      seen_result = {out_site_index, class_id, radius_sq, is_new_class, class_count,
                     table_full};
      if (results_due.size() == 0) begin
        faults++;
        if (faults <= REPORT_LIMIT)
          $display("%0t: result with none due: index %0d class %0d r2 %0d", $realtime,
                   out_site_index, class_id, radius_sq);
      end else begin
        due_result = results_due.pop_front();
        results_checked++;
        if (seen_result !== due_result) begin
          faults++;
          if (faults <= REPORT_LIMIT) begin
            $display("%0t: mismatch exp idx %0d id %0d r2 %0d new %0b cnt %0d full %0b",
                     $realtime, due_result.site_index, due_result.class_id,
                     due_result.radius_sq, due_result.fresh, due_result.count,
                     due_result.full);
            $display("%0t:          got idx %0d id %0d r2 %0d new %0b cnt %0d full %0b",
                     $realtime, seen_result.site_index, seen_result.class_id,
                     seen_result.radius_sq, seen_result.fresh, seen_result.count,
                     seen_result.full);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IDLE_LIMIT) begin
      $display("%0t: no item moved for %0d cycles", $realtime, IDLE_LIMIT);
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic push_site(input logic [COORD_W-1:0] t, input logic [COORD_W-1:0] x,
                           input logic [COORD_W-1:0] y, input logic [COORD_W-1:0] z,
                           input logic [INDEX_W-1:0] index);
    site_item_t s;
    s.t     = t;
    s.x     = x;
    s.y     = y;
    s.z     = z;
    s.index = index;
    site_queue.push_back(s);
    sites_pushed++;
  endtask

  // Sample at the falling edge so queue and start updates have settled
  task automatic wait_drained();
    do @(negedge clk);
    while (site_queue.size() != 0 || start || results_due.size() != 0);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    case (idx)
      REG_EXTENT_T: ext_t = data;
      REG_EXTENT_X: ext_x = data;
      REG_EXTENT_Y: ext_y = data;
      REG_EXTENT_Z: ext_z = data;
      REG_SOURCE_T: src_t = data[COORD_W-1:0];
      REG_SOURCE_X: src_x = data[COORD_W-1:0];
      REG_SOURCE_Y: src_y = data[COORD_W-1:0];
      REG_SOURCE_Z: src_z = data[COORD_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_geometry(input logic [CFG_DATA_W-1:0] et, input logic [CFG_DATA_W-1:0] ex,
                              input logic [CFG_DATA_W-1:0] ey, input logic [CFG_DATA_W-1:0] ez,
                              input logic [CFG_DATA_W-1:0] st, input logic [CFG_DATA_W-1:0] sx,
                              input logic [CFG_DATA_W-1:0] sy, input logic [CFG_DATA_W-1:0] sz);
    // every pending site must be scored under the old geometry
    wait_drained();
    cfg_write(REG_EXTENT_T, et);
    cfg_write(REG_EXTENT_X, ex);
    cfg_write(REG_EXTENT_Y, ey);
    cfg_write(REG_EXTENT_Z, ez);
    cfg_write(REG_SOURCE_T, st);
    cfg_write(REG_SOURCE_X, sx);
    cfg_write(REG_SOURCE_Y, sy);
    cfg_write(REG_SOURCE_Z, sz);
    @(posedge clk);
    cfg_we <= 1'b0;
    settings_applied++;
  endtask

  function automatic logic [INDEX_W-1:0] rand_index();
    return INDEX_W'($urandom_range(0, 65535));
  endfunction

  function automatic logic [COORD_W-1:0] rand_coord();
    return COORD_W'($urandom_range(0, 255));
  endfunction

  function automatic logic [CFG_DATA_W-1:0] rand_source();
    return CFG_DATA_W'($urandom_range(0, 511));
  endfunction

  // Small extents keep the set of distinct radii, and so the scan, short
  function automatic logic [EXTENT_W-1:0] pick_extent();
    int unsigned roll;
    roll = $urandom_range(0, 15);
    if (roll == 0) return '0;
    if (roll == 1) return EXTENT_W'(1);
    return EXTENT_W'($urandom_range(2, 8));
  endfunction

  function automatic logic [COORD_W-1:0] pick_below(input logic [EXTENT_W-1:0] ext);
    if (ext < 2) return COORD_W'($urandom_range(0, 3));
    return COORD_W'($urandom_range(0, ext - 1));
  endfunction

  function automatic logic [COORD_W-1:0] pick_coord(input logic [EXTENT_W-1:0] ext);
    // now and then a stray coordinate far outside the extent
    if ($urandom_range(0, 39) == 0) return rand_coord();
    return pick_below(ext);
  endfunction

  initial begin
    logic [EXTENT_W-1:0] e_t, e_x, e_y, e_z;
    int unsigned         chunk;
    int unsigned         guard;

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Reset geometry: extent 16, source at the origin
    push_site(8'd0, 8'd0, 8'd0, 8'd0, 16'h0000);
    push_site(8'd8, 8'd8, 8'd8, 8'd8, 16'hFFFF);
    push_site(8'd9, 8'd9, 8'd9, 8'd9, rand_index());
    push_site(8'd0, 8'd0, 8'd0, 8'd0, rand_index());
    push_site(8'd255, 8'd255, 8'd255, 8'd255, rand_index());
    push_site(8'd255, 8'd0, 8'd0, 8'd0, rand_index());
    push_site(8'd0, 8'd0, 8'd0, 8'd0, rand_index());

    // Negative wrap, sources at and beyond the extent
    set_geometry(9'd16, 9'd16, 9'd16, 9'd16, 9'd15, 9'd8, 9'd255, 9'd128);
    push_site(8'd7, 8'd0, 8'd0, 8'd0, rand_index());
    push_site(8'd15, 8'd8, 8'd255, 8'd128, rand_index());
    push_site(8'd6, 8'd0, 8'd247, 8'd120, rand_index());

    // Degenerate and widest extents; all-ones corner saturates the radius
    set_geometry(9'd0, 9'd1, 9'd2, 9'h1FF, 9'd0, 9'd0, 9'd0, 9'd0);
    push_site(8'd0, 8'd0, 8'd0, 8'd0, rand_index());
    push_site(8'd255, 8'd255, 8'd255, 8'd255, rand_index());
    push_site(8'd3, 8'd1, 8'd1, 8'd200, rand_index());

    // Upper source bit is dropped by the block
    set_geometry(9'd256, 9'd256, 9'd256, 9'd256, 9'h1FF, 9'h0FF, 9'h180, 9'h100);
    push_site(8'd0, 8'd0, 8'd0, 8'd0, rand_index());
    push_site(8'd127, 8'd127, 8'd128, 8'd128, rand_index());
    push_site(8'd255, 8'd255, 8'd255, 8'd255, rand_index());

    set_geometry(9'd2, 9'd2, 9'd2, 9'd2, 9'd1, 9'd0, 9'd1, 9'd0);
    push_site(8'd0, 8'd1, 8'd0, 8'd1, rand_index());
    push_site(8'd1, 8'd0, 8'd1, 8'd0, rand_index());
    push_site(8'd1, 8'd1, 8'd1, 8'd1, rand_index());

    // Random geometries; each one starts from a fully drained block
    while (sites_pushed < BULK_END) begin
      e_t = pick_extent();
      e_x = pick_extent();
      e_y = pick_extent();
      e_z = pick_extent();
      set_geometry(e_t, e_x, e_y, e_z, CFG_DATA_W'(pick_below(e_t)),
                   CFG_DATA_W'(pick_below(e_x)), CFG_DATA_W'(pick_below(e_y)),
                   CFG_DATA_W'(pick_below(e_z)));
      chunk = $urandom_range(20, 120);
      repeat (chunk)
        push_site(pick_coord(e_t), pick_coord(e_x), pick_coord(e_y), pick_coord(e_z),
                  rand_index());
    end

    // Wide lattice with full-range coordinates: open classes until none is free
    set_geometry(9'h1FF, 9'h1FF, 9'h1FF, 9'h1FF, rand_source(), rand_source(),
                 rand_source(), rand_source());
    guard = 0;
    while (classes_open < CLASS_SLOTS && guard < 64) begin
      repeat (32)
        push_site(rand_coord(), rand_coord(), rand_coord(), rand_coord(), rand_index());
      wait_drained();
      guard++;
    end

    // Full list: misses are refused, the zero radius still matches
    repeat (24) begin
      if ($urandom_range(0, 1) == 0)
        push_site(rand_coord(), rand_coord(), rand_coord(), rand_coord(), rand_index());
      else
        push_site(src_t, src_x, src_y, src_z, rand_index());
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sites sent %0d, results checked %0d, geometries written %0d",
             sites_accepted, results_checked, settings_applied);
    $display("Classes opened %0d of %0d, sites refused on a full list %0d",
             classes_open, CLASS_SLOTS, sites_refused);
    if (faults == 0 && results_due.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches, %0d results still due", faults, results_due.size());
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

FILE: sim.f
hdl/lrca_pkg.sv
hdl/lrca_ctrl.sv
hdl/lrca_datapath.sv
hdl/lattice_radius_class_assigner.sv
hdl/lrca_checker.sv
test/testbench.sv
